[rtl/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants of the Sobel edge magnitude block
// Register map codes, reset values, limits and the per-item control word
// handed from the front end to the back end.
// ----------------------------------------------------------------------------
package sem_pkg;

    // register map (word index = paddr[2])
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // request kinds on s_tuser
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam int IMAGE_WIDTH_W  = 11;
    localparam int IMAGE_HEIGHT_W = 13;
    localparam int ROW_W          = 13;
    localparam int EDGE_W         = 11;
    localparam int OUT_DATA_W     = 24;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;
    localparam logic [IMAGE_HEIGHT_W-1:0] HEIGHT_LIMIT       = 13'd4096;
    localparam logic [EDGE_W-1:0]         EDGE_LIMIT         = 11'd2047;

    // per-item control: result wanted, last result of frame, border masks
    typedef struct packed {
        logic produce;
        logic done;
        logic has_top;
        logic has_bot;
        logic has_left;
        logic has_right;
    } edge_ctl_t;

endpackage

[rtl/sem_ram.sv]
// ----------------------------------------------------------------------------
// sem_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/sem_queue.sv]
// ----------------------------------------------------------------------------
// sem_queue: short flop-based FIFO between front end and back end
// Push and pop may happen in the same cycle; ready depends on fill only.
// ----------------------------------------------------------------------------
module sem_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != NW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[rtl/sem_front.sv]
// ----------------------------------------------------------------------------
// sem_front: configuration registers and item classification
// Holds image size, tracks the raster position, drops early flushes and
// tags each remaining item with its border masks and result flags.
// ----------------------------------------------------------------------------
module sem_front
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          req_type,
    input  logic [PIXEL_BITS-1:0]         pixel_value,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic [$clog2(MAX_WIDTH)-1:0]  push_addr,
    output logic [PIXEL_BITS-1:0]         push_pixel,
    output edge_ctl_t                     push_ctl,
    output logic                          restart
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int W_RESET = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;

    logic [IMAGE_WIDTH_W-1:0]  width_raw_reg, width_raw_next;
    logic [IMAGE_HEIGHT_W-1:0] height_raw_reg, height_raw_next;
    logic [WW-1:0]             width_eff_reg, width_eff_next;
    logic [IMAGE_HEIGHT_W-1:0] height_eff_reg, height_eff_next;
    logic [CW-1:0]             col_reg, col_next;
    logic [ROW_W-1:0]          row_reg, row_next;

    logic                      cfg_write, accept, draining, process, col_zero, col_wrap;
    logic [IMAGE_WIDTH_W-1:0]  wv;
    logic [IMAGE_HEIGHT_W-1:0] hv;
    edge_ctl_t                 ctl;

    assign cfg_write = psel && penable && pwrite;
    assign restart   = cfg_write;
    assign prdata    = (paddr[2] == REG_IMAGE_HEIGHT) ?
                       APB_DATA_W'(height_raw_reg) : APB_DATA_W'(width_raw_reg);

    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;
    assign wv       = pwdata[IMAGE_WIDTH_W-1:0];
    assign hv       = pwdata[IMAGE_HEIGHT_W-1:0];

    // classify against the current raster position
    always_comb
    begin
        draining = row_reg >= height_eff_reg;
        process  = (req_type == REQ_PIXEL) || draining;
        col_zero = col_reg == '0;
        col_wrap = (WW'(col_reg) + WW'(1)) >= width_eff_reg;

        ctl.produce   = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && !col_zero);
        ctl.done      = col_zero &&
                        ({1'b0, row_reg} == ({1'b0, height_eff_reg} + (ROW_W + 1)'(1)));
        ctl.has_right = !col_zero;
        if (col_zero)
        begin
            ctl.has_left = width_eff_reg >= WW'(2);
            ctl.has_top  = row_reg >= ROW_W'(3);
            ctl.has_bot  = {1'b0, row_reg} <= {1'b0, height_eff_reg};
        end
        else
        begin
            ctl.has_left = col_reg >= CW'(2);
            ctl.has_top  = row_reg >= ROW_W'(2);
            ctl.has_bot  = row_reg < height_eff_reg;
        end
    end

    assign push_valid = accept && process;
    assign push_addr  = col_reg;
    assign push_pixel = draining ? '0 : pixel_value;
    assign push_ctl   = ctl;

    always_comb
    begin
        width_raw_next  = width_raw_reg;
        height_raw_next = height_raw_reg;
        width_eff_next  = width_eff_reg;
        height_eff_next = height_eff_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        if (cfg_write)
        begin
            // restart the frame on any register write
            col_next = '0;
            row_next = '0;
            unique case (paddr[2])
                REG_IMAGE_WIDTH:
                begin
                    width_raw_next = wv;
                    if (wv == '0)
                    begin
                        width_eff_next = WW'(1);
                    end
                    else if (32'(wv) > 32'(MAX_WIDTH))
                    begin
                        width_eff_next = WW'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_eff_next = WW'(wv);
                    end
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_raw_next = hv;
                    if (hv == '0)
                    begin
                        height_eff_next = IMAGE_HEIGHT_W'(1);
                    end
                    else if (hv > HEIGHT_LIMIT)
                    begin
                        height_eff_next = HEIGHT_LIMIT;
                    end
                    else
                    begin
                        height_eff_next = hv;
                    end
                end
                default:
                begin
                    width_raw_next = width_raw_reg;
                end
            endcase
        end
        else if (push_valid)
        begin
            if (ctl.done)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_wrap)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_raw_reg  <= IMAGE_WIDTH_RESET;
            height_raw_reg <= IMAGE_HEIGHT_RESET;
            width_eff_reg  <= WW'(W_RESET);
            height_eff_reg <= IMAGE_HEIGHT_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else
        begin
            width_raw_reg  <= width_raw_next;
            height_raw_reg <= height_raw_next;
            width_eff_reg  <= width_eff_next;
            height_eff_reg <= height_eff_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
        end
    end

endmodule

[rtl/sem_back.sv]
// ----------------------------------------------------------------------------
// sem_back: line stores, 3x3 window, gradient and magnitude pipeline
// Three stages under one advance enable: line read, gradients, magnitude and
// running maximum into the output register.
// ----------------------------------------------------------------------------
module sem_back
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         restart,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic [$clog2(MAX_WIDTH)-1:0] q_addr,
    input  logic [PIXEL_BITS-1:0]        q_pixel,
    input  edge_ctl_t                    q_ctl,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [EDGE_W-1:0]            edge_value,
    output logic [EDGE_W-1:0]            frame_max,
    output logic                         frame_done
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int P     = PIXEL_BITS;
    localparam int GW    = PIXEL_BITS + 3;
    localparam int SUM_W = (GW > EDGE_W) ? GW : EDGE_W;

    logic                en, pop;
    // stage 1: line store data arriving
    logic                s1_valid_reg;
    logic [CW-1:0]       s1_addr_reg;
    logic [P-1:0]        s1_pixel_reg;
    edge_ctl_t           s1_ctl_reg;
    // write bypass for a read that met a write to the same column
    logic                fwd_valid_reg;
    logic [CW-1:0]       fwd_addr_reg;
    logic [2*P-1:0]      fwd_data_reg;
    // stage 2: gradients
    logic                s2_valid_reg;
    logic signed [GW-1:0] s2_gx_reg, s2_gy_reg;
    edge_ctl_t           s2_ctl_reg;
    // output and running maximum
    logic                out_valid_reg;
    logic [EDGE_W-1:0]   edge_reg, max_out_reg, max_reg;
    logic                done_reg;

    logic [P-1:0]        c1_reg [3];
    logic [P-1:0]        c2_reg [3];
    logic [P-1:0]        new_col [3];
    logic [P-1:0]        a [3][3];
    logic [2*P-1:0]      rdata, line_cur;
    logic [GW-1:0]       lsum, rsum, tsum, bsum;
    logic signed [GW-1:0] gx, gy;
    logic [GW-1:0]       abs_gx, abs_gy;
    logic [SUM_W-1:0]    mag;
    logic [EDGE_W-1:0]   edge_sat, max_next;

    assign en      = !out_valid_reg || out_ready;
    assign pop     = en && q_valid;
    assign q_ready = en;

    // upper line in the high half, middle line in the low half
    sem_ram #(
        .WIDTH(2 * P),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .clk  (clk),
        .we   (en && s1_valid_reg),
        .waddr(s1_addr_reg),
        .wdata({new_col[1], s1_pixel_reg}),
        .re   (pop),
        .raddr(q_addr),
        .rdata(rdata)
    );

    always_comb
    begin
        line_cur   = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rdata;
        new_col[0] = line_cur[2*P-1:P];
        new_col[1] = line_cur[P-1:0];
        new_col[2] = s1_pixel_reg;
        for (int r = 0; r < 3; r++)
        begin
            a[r][0] = c1_reg[r];
            a[r][1] = c2_reg[r];
            a[r][2] = new_col[r];
            for (int k = 0; k < 3; k++)
            begin
                if ((r == 0 && !s1_ctl_reg.has_top) || (r == 2 && !s1_ctl_reg.has_bot) ||
                    (k == 0 && !s1_ctl_reg.has_left) || (k == 2 && !s1_ctl_reg.has_right))
                begin
                    a[r][k] = '0;
                end
            end
        end
        lsum = GW'(a[0][0]) + (GW'(a[1][0]) << 1) + GW'(a[2][0]);
        rsum = GW'(a[0][2]) + (GW'(a[1][2]) << 1) + GW'(a[2][2]);
        tsum = GW'(a[0][0]) + (GW'(a[0][1]) << 1) + GW'(a[0][2]);
        bsum = GW'(a[2][0]) + (GW'(a[2][1]) << 1) + GW'(a[2][2]);
        gx   = $signed(lsum - rsum);
        gy   = $signed(tsum - bsum);
    end

    always_comb
    begin
        abs_gx   = s2_gx_reg[GW-1] ? GW'(-s2_gx_reg) : GW'(s2_gx_reg);
        abs_gy   = s2_gy_reg[GW-1] ? GW'(-s2_gy_reg) : GW'(s2_gy_reg);
        mag      = SUM_W'(abs_gx) + SUM_W'(abs_gy);
        edge_sat = (mag > SUM_W'(EDGE_LIMIT)) ? EDGE_LIMIT : mag[EDGE_W-1:0];
        max_next = (edge_sat > max_reg) ? edge_sat : max_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_reg       <= '0;
            for (int r = 0; r < 3; r++)
            begin
                c1_reg[r] <= '0;
                c2_reg[r] <= '0;
            end
        end
        else
        begin
            if (restart)
            begin
                max_reg <= '0;
            end
            if (en)
            begin
                s1_valid_reg  <= q_valid;
                fwd_valid_reg <= s1_valid_reg;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg && s2_ctl_reg.produce;
                if (s1_valid_reg)
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        c1_reg[r] <= c2_reg[r];
                        c2_reg[r] <= new_col[r];
                    end
                end
                if (s2_valid_reg && s2_ctl_reg.produce && !restart)
                begin
                    max_reg <= s2_ctl_reg.done ? '0 : max_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (q_valid)
            begin
                s1_addr_reg  <= q_addr;
                s1_pixel_reg <= q_pixel;
                s1_ctl_reg   <= q_ctl;
            end
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= {new_col[1], s1_pixel_reg};
            s2_gx_reg    <= gx;
            s2_gy_reg    <= gy;
            s2_ctl_reg   <= s1_ctl_reg;
            edge_reg     <= edge_sat;
            max_out_reg  <= max_next;
            done_reg     <= s2_ctl_reg.done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_value = edge_reg;
    assign frame_max  = max_out_reg;
    assign frame_done = done_reg;

endmodule

[rtl/sobel_edge_magnitude.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude: streaming 3x3 Sobel edge detector, |Gx| + |Gy|
// Raster-order grayscale in, one edge value per pixel out with the frame's
// running maximum; neighbours outside the image count as zero.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Carries
//  s_*       in         s_tvalid / s_tready       pixel or flush request
//  m_*       out        m_tvalid / m_tready       edge value, frame max, done
//  APB       in/out     psel, penable, pready     image_width, image_height
//
//  One item is taken per clock when the output side keeps up. An accepted
//  item passes the queue and stages 1 and 2 into the output register; each
//  result belongs to the pixel one row plus one pixel earlier, so
//  image_width + 1 flush items drain a frame. The line-store RAM port and
//  the 3x3 window update set the one-item-per-clock figure. rst_n clears
//  counters, valid bits and the running maximum; line stores are not
//  cleared. Output stalls freeze the back end; the two-entry queue then
//  fills and drops s_tready.
module sobel_edge_magnitude
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [APB_ADDR_W-1:0]             paddr,
    input  logic [APB_DATA_W-1:0]             pwdata,
    output logic [APB_DATA_W-1:0]             prdata,
    output logic                              pready,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]   s_tdata,  // pixel_value
    input  logic                              s_tuser,  // req_type
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_DATA_W-1:0]             m_tdata,  // edge_value, frame_max
    output logic                              m_tlast   // frame_done
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = $bits(edge_ctl_t);
    localparam int QW = CW + PIXEL_BITS + EW;

    logic                  push_valid, push_ready, restart;
    logic [CW-1:0]         push_addr;
    logic [PIXEL_BITS-1:0] push_pixel;
    edge_ctl_t             push_ctl;
    logic                  q_valid, q_ready;
    logic [QW-1:0]         q_data;
    logic [EW-1:0]         q_ctl_bits;
    logic [EDGE_W-1:0]     edge_value, frame_max;

    assign pready = 1'b1;

    // classify and count positions
    sem_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .req_type   (s_tuser),
        .pixel_value(s_tdata[PIXEL_BITS-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_addr  (push_addr),
        .push_pixel (push_pixel),
        .push_ctl   (push_ctl),
        .restart    (restart)
    );

    // decouple the front from back-end stalls
    sem_queue #(
        .WIDTH(QW),
        .DEPTH(2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (push_valid),
        .in_ready (push_ready),
        .in_data  ({push_addr, push_pixel, push_ctl}),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_data)
    );

    assign q_ctl_bits = q_data[EW-1:0];

    // line stores, window, gradients, magnitude
    sem_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_addr    (q_data[QW-1:PIXEL_BITS+EW]),
        .q_pixel   (q_data[PIXEL_BITS+EW-1:EW]),
        .q_ctl     (edge_ctl_t'(q_ctl_bits)),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .edge_value(edge_value),
        .frame_max (frame_max),
        .frame_done(m_tlast)
    );

    // pad the two 11-bit fields up to whole bytes
    assign m_tdata = {(OUT_DATA_W - 2 * EDGE_W)'(0), frame_max, edge_value};

endmodule
